>>> rtl/dfd_pkg.sv
`default_nettype none

package dfd_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NUM = 2'd0;
    localparam kind_t KIND_NAN = 2'd1;
    localparam kind_t KIND_INF = 2'd2;
    localparam kind_t KIND_BIG = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic        sign;
        logic        plus;
        logic [10:0] efield;
        logic [51:0] mant;
        logic [5:0]  prec;
    } conv_t;

    localparam logic [10:0] EXP_INF     = 11'h7ff;
    localparam logic [10:0] EXP_BIAS    = 11'd1023;
    localparam logic [10:0] EXP_MAX_INT = 11'd1075;

    localparam logic [63:0] OFF_HALF  = 64'h3FE0000000000000;
    localparam logic [63:0] OFF_WIDE  = 64'h3FE051EB851EB852;
    localparam logic [52:0] TENTH_MANT = 53'h1999999999999A;
    localparam logic [10:0] TENTH_EXP  = 11'h3FB;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_F     = 8'h46;

endpackage

`default_nettype wire

>>> rtl/dfd_front.sv
`default_nettype none

module dfd_front #(
    parameter int MAX_PREC = 46
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [63:0]   value_bits,
    input  wire logic [5:0]    precision,
    input  wire logic          force_plus,
    output logic               push,
    input  wire logic          q_full,
    output dfd_pkg::conv_t     push_item
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_MRND  = 3'd2;
    localparam logic [2:0] F_ALIGN = 3'd3;
    localparam logic [2:0] F_ADD   = 3'd4;
    localparam logic [2:0] F_PUSH  = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [63:0]    v_reg, v_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [1:0]     phase_reg, phase_next;
    logic [52:0]    om_reg, om_next;
    logic [10:0]    oe_reg, oe_next;
    logic [105:0]   acc_reg, acc_next;
    logic [55:0]    big_reg, big_next;
    logic [55:0]    al_reg, al_next;
    logic [10:0]    ae_reg, ae_next;
    dfd_pkg::conv_t item_reg, item_next;

    logic [5:0]   prec_clamp;
    logic [26:0]  pa;
    logic [26:0]  pb;
    logic [53:0]  pp;
    logic [6:0]   pp_sh;
    logic [52:0]  nm;
    logic         ng;
    logic         nst;
    logic [10:0]  ne;
    logic [53:0]  nmr;
    logic [10:0]  ev;
    logic [52:0]  mv;
    logic [10:0]  eve;
    logic [52:0]  lm;
    logic [52:0]  sm;
    logic [10:0]  le;
    logic [10:0]  d;
    logic [111:0] wide;
    logic [56:0]  s57;
    logic [55:0]  n56;
    logic [11:0]  se;
    logic [53:0]  mr;
    logic [52:0]  m53;
    logic         up;

    assign prec_clamp = (precision > MAX_PREC[5:0]) ? MAX_PREC[5:0] : precision;
    assign in_stall   = (state_reg != F_IDLE);
    assign push       = (state_reg == F_PUSH) && !q_full;
    assign push_item  = item_reg;

    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                pa = om_reg[26:0];
                pb = dfd_pkg::TENTH_MANT[26:0];
                pp_sh = 7'd0;
            end
            2'd1:
            begin
                pa = om_reg[26:0];
                pb = {1'b0, dfd_pkg::TENTH_MANT[52:27]};
                pp_sh = 7'd27;
            end
            2'd2:
            begin
                pa = {1'b0, om_reg[52:27]};
                pb = dfd_pkg::TENTH_MANT[26:0];
                pp_sh = 7'd27;
            end
            default:
            begin
                pa = {1'b0, om_reg[52:27]};
                pb = {1'b0, dfd_pkg::TENTH_MANT[52:27]};
                pp_sh = 7'd54;
            end
        endcase
        pp = pa * pb;
    end

    // product normalise and round to nearest even
    always_comb
    begin
        if (acc_reg[105])
        begin
            nm  = acc_reg[105:53];
            ng  = acc_reg[52];
            nst = |acc_reg[51:0];
            ne  = oe_reg - 11'd3;
        end
        else
        begin
            nm  = acc_reg[104:52];
            ng  = acc_reg[51];
            nst = |acc_reg[50:0];
            ne  = oe_reg - 11'd4;
        end
        nmr = {1'b0, nm} + {53'd0, ng && (nst || nm[0])};
    end

    // alignment of the smaller operand
    always_comb
    begin
        ev  = v_reg[62:52];
        mv  = {ev != 11'd0, v_reg[51:0]};
        eve = (ev == 11'd0) ? 11'd1 : ev;
        if (eve >= oe_reg)
        begin
            lm = mv;
            le = eve;
            sm = om_reg;
            d  = eve - oe_reg;
        end
        else
        begin
            lm = om_reg;
            le = oe_reg;
            sm = mv;
            d  = oe_reg - eve;
        end
        wide = {sm, 3'b000, 56'd0} >> d[5:0];
    end

    // magnitude add and round
    always_comb
    begin
        s57 = {1'b0, big_reg} + {1'b0, al_reg};
        if (s57[56])
        begin
            n56 = {s57[56:2], s57[1] | s57[0]};
            se  = {1'b0, ae_reg} + 12'd1;
        end
        else
        begin
            n56 = s57[55:0];
            se  = {1'b0, ae_reg};
        end
        up = n56[2] && (n56[1] || n56[0] || n56[3]);
        mr = {1'b0, n56[55:3]} + {53'd0, up};
        if (mr[53])
        begin
            m53 = mr[53:1];
            se  = se + 12'd1;
        end
        else
        begin
            m53 = mr[52:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        om_next    = om_reg;
        oe_next    = oe_reg;
        acc_next   = acc_reg;
        big_next   = big_reg;
        al_next    = al_reg;
        ae_next    = ae_reg;
        item_next  = item_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = value_bits;
                    cnt_next   = prec_clamp;
                    phase_next = 2'd0;
                    acc_next   = '0;
                    if (prec_clamp > 6'd1)
                    begin
                        om_next = {1'b1, dfd_pkg::OFF_HALF[51:0]};
                        oe_next = dfd_pkg::OFF_HALF[62:52];
                    end
                    else
                    begin
                        om_next = {1'b1, dfd_pkg::OFF_WIDE[51:0]};
                        oe_next = dfd_pkg::OFF_WIDE[62:52];
                    end
                    item_next.sign   = value_bits[63];
                    item_next.plus   = force_plus;
                    item_next.prec   = prec_clamp;
                    item_next.efield = value_bits[62:52];
                    item_next.mant   = value_bits[51:0];
                    if (value_bits[62:52] == dfd_pkg::EXP_INF)
                    begin
                        item_next.kind = (value_bits[51:0] != 52'd0) ?
                                         dfd_pkg::KIND_NAN : dfd_pkg::KIND_INF;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        item_next.kind = dfd_pkg::KIND_NUM;
                        state_next = (prec_clamp == 6'd0) ? F_ALIGN : F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                acc_next   = acc_reg + ({52'd0, pp} << pp_sh);
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    state_next = F_MRND;
                end
            end
            F_MRND:
            begin
                if (nmr[53])
                begin
                    om_next = nmr[53:1];
                    oe_next = ne + 11'd1;
                end
                else
                begin
                    om_next = nmr[52:0];
                    oe_next = ne;
                end
                acc_next   = '0;
                phase_next = 2'd0;
                cnt_next   = cnt_reg - 6'd1;
                state_next = (cnt_reg == 6'd1) ? F_ALIGN : F_MUL;
            end
            F_ALIGN:
            begin
                big_next = {lm, 3'b000};
                ae_next  = le;
                if (d >= 11'd56)
                begin
                    al_next = {55'd0, |sm};
                end
                else
                begin
                    al_next = {wide[111:57], wide[56] | (|wide[55:0])};
                end
                state_next = F_ADD;
            end
            F_ADD:
            begin
                item_next.sign = v_reg[63] && (v_reg[62:0] != 63'd0);
                if (se >= {1'b0, dfd_pkg::EXP_INF})
                begin
                    item_next.kind   = dfd_pkg::KIND_INF;
                    item_next.efield = dfd_pkg::EXP_INF;
                    item_next.mant   = '0;
                end
                else
                begin
                    item_next.efield = se[10:0];
                    item_next.mant   = m53[51:0];
                    item_next.kind   = (se[10:0] > dfd_pkg::EXP_MAX_INT) ?
                                       dfd_pkg::KIND_BIG : dfd_pkg::KIND_NUM;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        om_reg    <= om_next;
        oe_reg    <= oe_next;
        acc_reg   <= acc_next;
        big_reg   <= big_next;
        al_reg    <= al_next;
        ae_reg    <= ae_next;
        item_reg  <= item_next;
    end

endmodule

`default_nettype wire

>>> rtl/dfd_fifo.sv
`default_nettype none

module dfd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dfd_pkg::conv_t  push_item,
    output logic                 q_full,
    output logic                 q_valid,
    input  wire logic            pop,
    output dfd_pkg::conv_t       q_item
);

    dfd_pkg::conv_t mem [2];
    logic           wr_reg, wr_next;
    logic           rd_reg, rd_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dfd_back.sv
`default_nettype none

module dfd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire dfd_pkg::conv_t  q_item,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           char_code,
    output logic                 last,
    output logic                 too_large
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CONV = 3'd1;
    localparam logic [2:0] B_SIGN = 3'd2;
    localparam logic [2:0] B_INT  = 3'd3;
    localparam logic [2:0] B_DOT  = 3'd4;
    localparam logic [2:0] B_FRAC = 3'd5;
    localparam logic [2:0] B_TXT  = 3'd6;

    logic [2:0]     st_reg, st_next;
    dfd_pkg::conv_t it_reg, it_next;
    logic [52:0]    bin_reg, bin_next;
    logic [63:0]    bcd_reg, bcd_next;
    logic [52:0]    frac_reg, frac_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [1:0]     tidx_reg, tidx_next;
    logic           started_reg, started_next;
    logic           ov_reg, ov_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic           tl_reg, tl_next;

    logic               emit_ok;
    logic               emit;
    logic [7:0]         e_ch;
    logic               e_last;
    logic               e_tl;
    logic signed [11:0] ue;
    logic [11:0]        negsh;
    logic [52:0]        m53;
    logic [5:0]         ish;
    logic [105:0]       fwide;
    logic [52:0]        ipart;
    logic [52:0]        fpart;
    logic [63:0]        bcd_adj;
    logic [56:0]        f10;
    logic [3:0]         dig;
    logic               want_sign;

    assign emit_ok   = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign char_code = ch_reg;
    assign last      = last_reg;
    assign too_large = tl_reg;

    always_comb
    begin
        ue    = $signed({1'b0, q_item.efield}) - $signed({1'b0, dfd_pkg::EXP_BIAS});
        negsh = 12'd0 - (ue + 12'sd1);
        m53   = {1'b1, q_item.mant};
        ish   = 6'd52 - ue[5:0];
        ipart = m53 >> ish;
        fwide = {53'd0, m53} << (ue[5:0] + 6'd1);
        if (!ue[11])
        begin
            fpart = fwide[52:0];
        end
        else if (negsh < 12'd64)
        begin
            fpart = m53 >> negsh[5:0];
        end
        else
        begin
            fpart = '0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            bcd_adj[k*4 +: 4] = (bcd_reg[k*4 +: 4] >= 4'd5) ?
                                bcd_reg[k*4 +: 4] + 4'd3 : bcd_reg[k*4 +: 4];
        end
        f10 = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0};
        dig = f10[56:53];
        want_sign = it_reg.sign || (it_reg.plus && it_reg.kind == dfd_pkg::KIND_NUM);
    end

    always_comb
    begin
        st_next      = st_reg;
        it_next      = it_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        tidx_next    = tidx_reg;
        started_next = started_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        e_ch         = dfd_pkg::CH_ZERO;
        e_last       = 1'b0;
        e_tl         = 1'b0;
        unique case (st_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    it_next   = q_item;
                    bin_next  = ipart;
                    bcd_next  = '0;
                    frac_next = fpart;
                    tidx_next = 2'd0;
                    cnt_next  = 6'd53;
                    unique case (q_item.kind)
                        dfd_pkg::KIND_NUM: st_next = ue[11] ? B_SIGN : B_CONV;
                        dfd_pkg::KIND_INF: st_next = B_SIGN;
                        default:           st_next = B_TXT;
                    endcase
                end
            end
            B_CONV:
            begin
                bcd_next = {bcd_adj[62:0], bin_reg[52]};
                bin_next = {bin_reg[51:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    st_next = B_SIGN;
                end
            end
            B_SIGN:
            begin
                e_ch = it_reg.sign ? dfd_pkg::CH_MINUS : dfd_pkg::CH_PLUS;
                if (!want_sign || emit_ok)
                begin
                    emit         = want_sign;
                    cnt_next     = 6'd15;
                    started_next = 1'b0;
                    st_next      = (it_reg.kind == dfd_pkg::KIND_INF) ? B_TXT : B_INT;
                end
            end
            B_INT:
            begin
                e_ch   = dfd_pkg::CH_ZERO + {4'd0, bcd_reg[63:60]};
                e_last = (it_reg.prec == 6'd0) && (cnt_reg == 6'd0);
                if (started_reg || bcd_reg[63:60] != 4'd0 || cnt_reg == 6'd0)
                begin
                    if (emit_ok)
                    begin
                        emit         = 1'b1;
                        started_next = 1'b1;
                        bcd_next     = {bcd_reg[59:0], 4'd0};
                        cnt_next     = cnt_reg - 6'd1;
                        if (cnt_reg == 6'd0)
                        begin
                            st_next = (it_reg.prec == 6'd0) ? B_IDLE : B_DOT;
                        end
                    end
                end
                else
                begin
                    bcd_next = {bcd_reg[59:0], 4'd0};
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            B_DOT:
            begin
                e_ch = dfd_pkg::CH_DOT;
                if (emit_ok)
                begin
                    emit     = 1'b1;
                    cnt_next = 6'd0;
                    st_next  = B_FRAC;
                end
            end
            B_FRAC:
            begin
                e_ch   = dfd_pkg::CH_ZERO + {4'd0, dig};
                e_last = (cnt_reg == it_reg.prec - 6'd1);
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    frac_next = f10[52:0];
                    cnt_next  = cnt_reg + 6'd1;
                    if (e_last)
                    begin
                        st_next = B_IDLE;
                    end
                end
            end
            B_TXT:
            begin
                unique case (it_reg.kind)
                    dfd_pkg::KIND_NAN:
                    begin
                        e_ch   = (tidx_reg == 2'd1) ? dfd_pkg::CH_A : dfd_pkg::CH_N;
                        e_last = (tidx_reg == 2'd2);
                    end
                    dfd_pkg::KIND_INF:
                    begin
                        e_ch   = (tidx_reg == 2'd0) ? dfd_pkg::CH_I :
                                 (tidx_reg == 2'd1) ? dfd_pkg::CH_N : dfd_pkg::CH_F;
                        e_last = (tidx_reg == 2'd2);
                    end
                    default:
                    begin
                        e_ch   = dfd_pkg::CH_ZERO;
                        e_last = 1'b1;
                        e_tl   = 1'b1;
                    end
                endcase
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    tidx_next = tidx_reg + 2'd1;
                    if (e_last)
                    begin
                        st_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next   = ov_reg && out_stall;
        ch_next   = ch_reg;
        last_next = last_reg;
        tl_next   = tl_reg;
        if (emit)
        begin
            ov_next   = 1'b1;
            ch_next   = e_ch;
            last_next = e_last;
            tl_next   = e_tl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg      <= it_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        frac_reg    <= frac_next;
        cnt_reg     <= cnt_next;
        tidx_reg    <= tidx_next;
        started_reg <= started_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        tl_reg      <= tl_next;
    end

endmodule

`default_nettype wire

>>> rtl/double_to_fixed_decimal_text.sv
// Converts an IEEE double to fixed-point decimal text, one ASCII character per output item,
// the final one marked by last. The front end builds the rounding offset with a shared
// 27x27 multiplier, one multiplication by a tenth per fraction digit, then aligns and
// adds in its ALIGN and ADD states; a two-entry queue hands the rounded value to the back
// end. The back end converts binary to BCD when the value is one or more, handles the
// sign, skips up to 15 leading zeros, then emits one character per cycle while the output
// is not stalled. Front and back overlap on consecutive items.
`default_nettype none

module double_to_fixed_decimal_text #(
    parameter int MAX_PREC = 46
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] value_bits,
    input  wire logic [5:0]  precision,
    input  wire logic        force_plus,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       char_code,
    output logic             last,
    output logic             too_large
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    dfd_pkg::conv_t push_item;
    dfd_pkg::conv_t q_item;

    dfd_front #(
        .MAX_PREC (MAX_PREC)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_bits (value_bits),
        .precision  (precision),
        .force_plus (force_plus),
        .push       (push),
        .q_full     (q_full),
        .push_item  (push_item)
    );

    dfd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_item    (q_item)
    );

    dfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last),
        .too_large (too_large)
    );

endmodule

`default_nettype wire
